// File: rtl/core/assert_macros.svh
// assertion helpers shared by the core files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge out of reset
`define PWPFG_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

// consequent must hold on the clock edge after the antecedent
`define PWPFG_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/pwpfg_pkg.sv
package pwpfg_pkg;

   localparam int CELL_BITS  = 16;
   localparam int TRIG_DEPTH = 1024;
   localparam int TRIG_BITS  = $clog2(TRIG_DEPTH);
   localparam int ADDR_W     = TRIG_BITS + 1;

   localparam int IN_W       = 16;
   localparam int CELL_USE   = (CELL_BITS < IN_W) ? CELL_BITS : IN_W;
   localparam int QW         = CELL_BITS + 1;
   localparam int LEN_W      = 20;
   localparam int POS_W      = (QW > LEN_W) ? QW : LEN_W;
   localparam int NUM_W      = LEN_W + TRIG_BITS + 1;
   localparam int PH_W       = 16;
   localparam int AMP_W      = 16;
   localparam int POL_W      = 16;
   localparam int SIN_W      = 17;
   localparam int ENV_W      = 17;
   localparam int CAR_W      = SIN_W + 1;
   localparam int LENV_W     = AMP_W + ENV_W - 8;
   localparam int WPROD_W    = LENV_W + 1 + CAR_W;
   localparam int WAVE_W     = WPROD_W - 16;
   localparam int FPROD_W    = WAVE_W + POL_W;
   localparam int FIELD_W    = 24;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 20;

   localparam logic [ENV_W-1:0] ENV_ONE = ENV_W'(65536);
   localparam longint unsigned PI_2_Q30 = 64'd1686629713;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_START, CSR_RISE, CSR_FLAT, CSR_FALL,
      CSR_PHASE, CSR_AMP, CSR_POLC, CSR_POLS
   } csr_idx_type;

   typedef enum logic [1:0] {
      REG_ZERO, REG_RISE, REG_FLAT, REG_FALL
   } region_type;

   typedef struct packed {
      logic [LEN_W-1:0]        start_pos;
      logic [LEN_W-1:0]        rise_len;
      logic [LEN_W-1:0]        flat_len;
      logic [LEN_W-1:0]        fall_len;
      logic [PH_W-1:0]         phase_step;
      logic [AMP_W-1:0]        amplitude;
      logic signed [POL_W-1:0] pol_cos;
      logic signed [POL_W-1:0] pol_sin;
   } cfg_type;

   // sideband carried alongside the divider
   typedef struct packed {
      region_type        region;
      logic [ADDR_W-1:0] caddr;
      logic              cneg;
   } tag_type;

   typedef logic [SIN_W-1:0] sin_tab_type [0:TRIG_DEPTH];

   // quarter sine in Q1.16, taylor series to x^13 in Q2.30
   function automatic sin_tab_type build_sin_tab();
      sin_tab_type       tab;
      longint unsigned   x;
      longint unsigned   x2;
      longint unsigned   t;
      longint            sum;
      for (int i = 0; i <= TRIG_DEPTH; i++) begin
         x = (PI_2_Q30 * 64'(i) + 64'(TRIG_DEPTH / 2)) / 64'(TRIG_DEPTH);
         x2 = (x * x + (64'd1 << 29)) >> 30;
         sum = longint'(x);
         t = x;
         for (int n = 1; n <= 6; n++) begin
            t = ((t * x2) >> 30) / 64'(4 * n * n + 2 * n);
            if (n % 2 == 1) sum = sum - longint'(t);
            else sum = sum + longint'(t);
         end
         if (sum < 0) sum = 0;
         if (sum > (64'sd1 <<< 30)) sum = 64'sd1 <<< 30;
         tab[i] = SIN_W'((sum + 8192) >>> 14);
      end
      return tab;
   endfunction

endpackage

// File: rtl/core/pwpfg_rom.sv
module pwpfg_rom
   import pwpfg_pkg::*;
(
   input  logic              clock,
   input  logic              en,
   input  logic [ADDR_W-1:0] addr_a,
   input  logic [ADDR_W-1:0] addr_b,
   output logic [SIN_W-1:0]  rd_a,
   output logic [SIN_W-1:0]  rd_b
);

   localparam sin_tab_type SIN_TAB = build_sin_tab();

   logic [SIN_W-1:0] rd_a_ff;
   logic [SIN_W-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         rd_a_ff <= SIN_TAB[addr_a];
         rd_b_ff <= SIN_TAB[addr_b];
      end
   end

   assign rd_a = rd_a_ff;
   assign rd_b = rd_b_ff;

endmodule

// File: rtl/core/pwpfg_div.sv
`include "assert_macros.svh"

module pwpfg_div
   import pwpfg_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  in_num,
   input  logic [LEN_W-1:0]  in_den,
   input  tag_type           in_tag,
   output logic              out_valid,
   output logic [ADDR_W-1:0] out_quot,
   output tag_type           out_tag
);

   localparam int QB = ADDR_W;

   logic              vld_ff  [QB];
   logic [NUM_W-1:0]  rem_ff  [QB];
   logic [LEN_W-1:0]  den_ff  [QB];
   logic [QB-1:0]     quot_ff [QB];
   tag_type           tag_ff  [QB];

   // one quotient bit per stage, msb first
   for (genvar s = 0; s < QB; s++) begin : g_stg
      localparam int J = QB - 1 - s;
      logic             v_prev;
      logic [NUM_W-1:0] rem_prev;
      logic [LEN_W-1:0] den_prev;
      logic [QB-1:0]    q_prev;
      tag_type          tag_prev;
      logic [NUM_W-1:0] dsh;
      logic             ge;

      if (s == 0) begin : g_first
         assign v_prev   = in_valid;
         assign rem_prev = in_num;
         assign den_prev = in_den;
         assign q_prev   = '0;
         assign tag_prev = in_tag;
      end else begin : g_rest
         assign v_prev   = vld_ff[s-1];
         assign rem_prev = rem_ff[s-1];
         assign den_prev = den_ff[s-1];
         assign q_prev   = quot_ff[s-1];
         assign tag_prev = tag_ff[s-1];
      end

      assign dsh = NUM_W'(den_prev) << J;
      assign ge  = rem_prev >= dsh;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (en) begin
            vld_ff[s] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s]  <= ge ? (rem_prev - dsh) : rem_prev;
            den_ff[s]  <= den_prev;
            quot_ff[s] <= q_prev | (QB'(ge) << J);
            tag_ff[s]  <= tag_prev;
         end
      end
   end

   assign out_valid = vld_ff[QB-1];
   assign out_quot  = quot_ff[QB-1];
   assign out_tag   = tag_ff[QB-1];

   `PWPFG_ASSERT(a_quot_range, clock, reset,
      (!out_valid || !(out_tag.region == REG_RISE || out_tag.region == REG_FALL)
       || out_quot <= QB'(TRIG_DEPTH)), "ramp quotient beyond table depth")

endmodule

// File: rtl/core/pwpfg_lane.sv
`include "assert_macros.svh"

module pwpfg_lane
   import pwpfg_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_valid,
   input  logic [QW-1:0]             q,
   input  cfg_type                   cfg,
   output logic                      out_valid,
   output logic signed [WPROD_W-1:0] wave_prod
);

   // region and divider operands
   logic [POS_W-1:0]    q_ext;
   logic [POS_W-1:0]    st_ext;
   logic                ahead;
   logic [LEN_W-1:0]    d;
   logic [LEN_W:0]      rf;
   logic [LEN_W+1:0]    total;
   logic [LEN_W-1:0]    fall_base;
   logic [2*PH_W-1:0]   php;
   region_type          region_in;

   logic                f_vld_ff;
   region_type          region_ff;
   logic [LEN_W-1:0]    nb_ff;
   logic [LEN_W-1:0]    den_ff;
   logic [PH_W-1:0]     ph_ff;

   always_comb begin
      q_ext     = POS_W'(q);
      st_ext    = POS_W'(cfg.start_pos);
      ahead     = q_ext > st_ext;
      d         = LEN_W'(st_ext - q_ext);
      rf        = (LEN_W+1)'(cfg.rise_len) + (LEN_W+1)'(cfg.flat_len);
      total     = (LEN_W+2)'(rf) + (LEN_W+2)'(cfg.fall_len);
      fall_base = LEN_W'(total - (LEN_W+2)'(d));
      php       = q_ext[PH_W-1:0] * cfg.phase_step;
      if (ahead) region_in = REG_ZERO;
      else if (d < cfg.rise_len) region_in = REG_RISE;
      else if ((LEN_W+1)'(d) < rf) region_in = REG_FLAT;
      else if ((LEN_W+2)'(d) < total) region_in = REG_FALL;
      else region_in = REG_ZERO;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_vld_ff <= 1'b0;
      end else if (en) begin
         f_vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         region_ff <= region_in;
         nb_ff     <= (region_in == REG_FALL) ? fall_base : d;
         den_ff    <= (region_in == REG_FALL) ? cfg.fall_len : cfg.rise_len;
         ph_ff     <= php[PH_W-1:0];
      end
   end

   // numerator and carrier table address
   logic [NUM_W-1:0]       num_in;
   logic [PH_W+TRIG_BITS+2:0] kf;
   logic [TRIG_BITS+1:0]   k;
   tag_type                tag_in;

   logic                   n_vld_ff;
   logic [NUM_W-1:0]       num_ff;
   logic [LEN_W-1:0]       nden_ff;
   tag_type                tag_ff;

   always_comb begin
      num_in = NUM_W'({nb_ff, TRIG_BITS'(0)}) + NUM_W'(den_ff >> 1);
      kf = (PH_W+TRIG_BITS+3)'({ph_ff, (TRIG_BITS+2)'(0)})
         + (PH_W+TRIG_BITS+3)'(32768);
      k = kf[PH_W+TRIG_BITS+1:PH_W];
      tag_in.region = region_ff;
      tag_in.caddr  = k[TRIG_BITS] ? {1'b0, k[TRIG_BITS-1:0]}
                    : ADDR_W'(TRIG_DEPTH) - {1'b0, k[TRIG_BITS-1:0]};
      tag_in.cneg   = k[TRIG_BITS+1] ^ k[TRIG_BITS];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_vld_ff <= 1'b0;
      end else if (en) begin
         n_vld_ff <= f_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num_ff  <= num_in;
         nden_ff <= den_ff;
         tag_ff  <= tag_in;
      end
   end

   logic              d_vld;
   logic [ADDR_W-1:0] quot;
   tag_type           dtag;

   pwpfg_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (n_vld_ff),
      .in_num    (num_ff),
      .in_den    (nden_ff),
      .in_tag    (tag_ff),
      .out_valid (d_vld),
      .out_quot  (quot),
      .out_tag   (dtag)
   );

   // table reads for envelope and carrier
   logic [ADDR_W-1:0] eaddr;
   logic [SIN_W-1:0]  s_env;
   logic [SIN_W-1:0]  s_car;
   logic              r_vld_ff;
   region_type        r_region_ff;
   logic              r_neg_ff;

   assign eaddr = (quot > ADDR_W'(TRIG_DEPTH)) ? ADDR_W'(TRIG_DEPTH) : quot;

   pwpfg_rom u_rom (
      .clock  (clock),
      .en     (en),
      .addr_a (eaddr),
      .addr_b (dtag.caddr),
      .rd_a   (s_env),
      .rd_b   (s_car)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         r_vld_ff <= 1'b0;
      end else if (en) begin
         r_vld_ff <= d_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r_region_ff <= dtag.region;
         r_neg_ff    <= dtag.cneg;
      end
   end

   // sin squared envelope and signed carrier
   logic [2*SIN_W-1:0]       sq;
   logic [2*SIN_W-1:0]       sq_rnd;
   logic [ENV_W-1:0]         env_in;
   logic                     q_vld_ff;
   logic [ENV_W-1:0]         env_ff;
   logic signed [CAR_W-1:0]  car_ff;

   always_comb begin
      sq     = s_env * s_env;
      sq_rnd = sq + (2*SIN_W)'(32768);
      case (r_region_ff)
         REG_FLAT: env_in = ENV_ONE;
         REG_RISE,
         REG_FALL: env_in = sq_rnd[ENV_W+15:16];
         default:  env_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_vld_ff <= 1'b0;
      end else if (en) begin
         q_vld_ff <= r_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         env_ff <= env_in;
         car_ff <= r_neg_ff ? -$signed({1'b0, s_car}) : $signed({1'b0, s_car});
      end
   end

   // amplitude times envelope
   logic [AMP_W+ENV_W-1:0]  ae;
   logic                    l_vld_ff;
   logic [LENV_W-1:0]       lenv_ff;
   logic signed [CAR_W-1:0] car2_ff;

   assign ae = cfg.amplitude * env_ff + (AMP_W+ENV_W)'(128);

   always_ff @(posedge clock) begin
      if (reset) begin
         l_vld_ff <= 1'b0;
      end else if (en) begin
         l_vld_ff <= q_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lenv_ff <= ae[AMP_W+ENV_W-1:8];
         car2_ff <= car_ff;
      end
   end

   // envelope times carrier
   logic                      p_vld_ff;
   logic signed [WPROD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_vld_ff <= 1'b0;
      end else if (en) begin
         p_vld_ff <= l_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= $signed({1'b0, lenv_ff}) * car2_ff;
      end
   end

   assign out_valid = p_vld_ff;
   assign wave_prod = prod_ff;

   `PWPFG_ASSERT_NEXT(a_flat_full, clock, reset,
      (en && r_vld_ff && r_region_ff == REG_FLAT), (env_ff == ENV_ONE),
      "flat-top envelope is not full scale")

endmodule

// File: rtl/core/plane_wave_pulse_field_generator_unit.sv
// Plane-wave pulse field generator: each req_ transfer carries a cell index,
// each rsp_ transfer the transverse E field at that cell point and the B
// field half a cell further on, scaled by a sin squared rise/flat/fall
// envelope, a cosine carrier and the polarization pair, saturated to Q8.15.
// Throughput is one cell per clock while the rsp_ word is not held back;
// on the way to rsp_ each cell passes the pipelined divider that maps
// the distance into the rise or fall onto the quarter-sine table. Both
// positions run in their own lane with a dual-read table ROM each. Write the
// csr_ registers only while no cell is in flight.
`include "assert_macros.svh"

module plane_wave_pulse_field_generator_unit
   import pwpfg_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [IN_W-1:0]       req_tdata,   // cell_x
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [4*FIELD_W-1:0]  rsp_tdata,   // e_y, e_z, b_y, b_z
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_pos  <= '0;
         cfg_ff.rise_len   <= LEN_W'(1);
         cfg_ff.flat_len   <= '0;
         cfg_ff.fall_len   <= LEN_W'(1);
         cfg_ff.phase_step <= '0;
         cfg_ff.amplitude  <= '0;
         cfg_ff.pol_cos    <= POL_W'(32767);
         cfg_ff.pol_sin    <= '0;
      end else if (csr_we) begin
         case (csr_idx_type'(csr_addr))
            CSR_START: cfg_ff.start_pos  <= csr_wdata[LEN_W-1:0];
            CSR_RISE:  cfg_ff.rise_len   <= csr_wdata[LEN_W-1:0];
            CSR_FLAT:  cfg_ff.flat_len   <= csr_wdata[LEN_W-1:0];
            CSR_FALL:  cfg_ff.fall_len   <= csr_wdata[LEN_W-1:0];
            CSR_PHASE: cfg_ff.phase_step <= csr_wdata[PH_W-1:0];
            CSR_AMP:   cfg_ff.amplitude  <= csr_wdata[AMP_W-1:0];
            CSR_POLC:  cfg_ff.pol_cos    <= csr_wdata[POL_W-1:0];
            CSR_POLS:  cfg_ff.pol_sin    <= csr_wdata[POL_W-1:0];
            default: ;
         endcase
      end
   end

   // whole pipeline advances unless the output word is held
   logic en;
   logic rsp_vld_ff;
   assign en = !rsp_vld_ff || rsp_tready;
   assign req_tready = en;

   logic                in_vld_ff;
   logic [CELL_USE-1:0] cell_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (en) begin
         in_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cell_ff <= req_tdata[CELL_USE-1:0];
      end
   end

   logic [QW-1:0] q_e;
   logic [QW-1:0] q_b;
   assign q_e = QW'({cell_ff, 1'b0});
   assign q_b = q_e | QW'(1);

   logic                      ve_vld;
   logic                      vb_vld;
   logic signed [WPROD_W-1:0] prod_e;
   logic signed [WPROD_W-1:0] prod_b;

   pwpfg_lane u_lane_e (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (in_vld_ff),
      .q         (q_e),
      .cfg       (cfg_ff),
      .out_valid (ve_vld),
      .wave_prod (prod_e)
   );

   pwpfg_lane u_lane_b (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (in_vld_ff),
      .q         (q_b),
      .cfg       (cfg_ff),
      .out_valid (vb_vld),
      .wave_prod (prod_b)
   );

   // round half away from zero by 16 bits
   function automatic logic signed [WAVE_W-1:0] rnd_wave(
      input logic signed [WPROD_W-1:0] v);
      logic signed [WPROD_W:0] t;
      t = $signed({v[WPROD_W-1], v}) + (WPROD_W+1)'(32768)
        - (WPROD_W+1)'(v[WPROD_W-1]);
      return t[WPROD_W-1:16];
   endfunction

   function automatic logic signed [FPROD_W-16:0] rnd_field(
      input logic signed [FPROD_W-1:0] v);
      logic signed [FPROD_W:0] t;
      t = $signed({v[FPROD_W-1], v}) + (FPROD_W+1)'(32768)
        - (FPROD_W+1)'(v[FPROD_W-1]);
      return t[FPROD_W:16];
   endfunction

   function automatic logic [FIELD_W-1:0] sat_field(
      input logic signed [FPROD_W-15:0] v);
      logic signed [FPROD_W-15:0] hi;
      logic signed [FPROD_W-15:0] lo;
      hi = (FPROD_W-14)'((1 << (FIELD_W-1)) - 1);
      lo = -(FPROD_W-14)'(1 << (FIELD_W-1));
      if (v > hi) return hi[FIELD_W-1:0];
      else if (v < lo) return lo[FIELD_W-1:0];
      else return v[FIELD_W-1:0];
   endfunction

   // wave rounding and polarization split
   logic signed [WAVE_W-1:0] wave_e;
   logic signed [WAVE_W-1:0] wave_b;
   assign wave_e = rnd_wave(prod_e);
   assign wave_b = rnd_wave(prod_b);

   logic                      w_vld_ff;
   logic signed [FPROD_W-1:0] fp_ey_ff;
   logic signed [FPROD_W-1:0] fp_ez_ff;
   logic signed [FPROD_W-1:0] fp_by_ff;
   logic signed [FPROD_W-1:0] fp_bz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         w_vld_ff <= 1'b0;
      end else if (en) begin
         w_vld_ff <= ve_vld && vb_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fp_ey_ff <= wave_e * cfg_ff.pol_cos;
         fp_ez_ff <= wave_e * cfg_ff.pol_sin;
         fp_by_ff <= wave_b * cfg_ff.pol_sin;
         fp_bz_ff <= wave_b * cfg_ff.pol_cos;
      end
   end

   // final rounding, b_y sign flip and saturation
   logic [4*FIELD_W-1:0] rsp_data_in;
   logic [4*FIELD_W-1:0] rsp_data_ff;

   always_comb begin
      rsp_data_in[FIELD_W-1:0]           = sat_field((FPROD_W-14)'(rnd_field(fp_ey_ff)));
      rsp_data_in[2*FIELD_W-1:FIELD_W]   = sat_field((FPROD_W-14)'(rnd_field(fp_ez_ff)));
      rsp_data_in[3*FIELD_W-1:2*FIELD_W] = sat_field(-(FPROD_W-14)'(rnd_field(fp_by_ff)));
      rsp_data_in[4*FIELD_W-1:3*FIELD_W] = sat_field((FPROD_W-14)'(rnd_field(fp_bz_ff)));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (en) begin
         rsp_vld_ff <= w_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

   `PWPFG_ASSERT(a_lanes_lockstep, clock, reset, (ve_vld == vb_vld),
      "E and B lanes out of step")

endmodule

// File: bench/tb.sv
`timescale 1ns / 100ps

module tb;
   import pwpfg_pkg::*;

   // expected field words for every cell in flight, plus the register shadow
   class field_scoreboard;
      longint unsigned start_pos, rise_len, flat_len, fall_len, phase_step, amplitude;
      longint pol_cos, pol_sin;
      longint unsigned qsine [0:1024];
      logic [4*FIELD_W-1:0] pending [$];
      int errors;

      function new();
         longint unsigned x;
         longint unsigned x2;
         longint unsigned t;
         longint sum;
         for (int i = 0; i <= 1024; i++) begin
            x = (64'd1686629713 * longint'(i) + 512) / 1024;
            x2 = (x * x + (64'd1 << 29)) >> 30;
            sum = longint'(x);
            t = x;
            for (int n = 1; n <= 6; n++) begin
               t = ((t * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
               if (n % 2) sum -= longint'(t);
               else sum += longint'(t);
            end
            if (sum < 0) sum = 0;
            if (sum > (64'sd1 <<< 30)) sum = 64'sd1 <<< 30;
            qsine[i] = (unsigned'(sum) + 8192) >> 14;
         end
         start_pos = 0; rise_len = 1; flat_len = 0; fall_len = 1;
         phase_step = 0; amplitude = 0; pol_cos = 32767; pol_sin = 0;
         errors = 0;
      endfunction

      function void set_reg(csr_idx_type idx, logic [CSR_DATA_W-1:0] v);
         case (idx)
            CSR_START: start_pos = 64'(v);
            CSR_RISE:  rise_len = 64'(v);
            CSR_FLAT:  flat_len = 64'(v);
            CSR_FALL:  fall_len = 64'(v);
            CSR_PHASE: phase_step = 64'(v[15:0]);
            CSR_AMP:   amplitude = 64'(v[15:0]);
            CSR_POLC:  pol_cos = longint'($signed(v[15:0]));
            CSR_POLS:  pol_sin = longint'($signed(v[15:0]));
            default: ;
         endcase
      endfunction

      function longint unsigned sin_sq(longint unsigned i);
         longint unsigned s;
         s = qsine[(i > 1024) ? 1024 : i];
         return (s * s + 32768) >> 16;
      endfunction

      function longint unsigned envelope(longint unsigned q);
         longint unsigned d;
         longint unsigned rf;
         longint unsigned total;
         if (q > start_pos) return 0;
         d = start_pos - q;
         rf = rise_len + flat_len;
         total = rf + fall_len;
         if (d < rise_len) return sin_sq((d * 1024 + rise_len / 2) / rise_len);
         if (d < rf) return 65536;
         if (d < total) return sin_sq(((total - d) * 1024 + fall_len / 2) / fall_len);
         return 0;
      endfunction

      function longint cosine(longint unsigned q);
         longint unsigned ph;
         longint unsigned k;
         longint unsigned r;
         ph = (q * phase_step) & 64'hFFFF;
         k = ((ph * 4096 + 32768) >> 16) % 4096;
         r = k % 1024;
         case (k / 1024)
            0: return longint'(qsine[1024 - r]);
            1: return -longint'(qsine[r]);
            2: return -longint'(qsine[1024 - r]);
            default: return longint'(qsine[r]);
         endcase
      endfunction

      function longint round_off(longint v, int sh);
         longint m;
         m = (v < 0) ? -v : v;
         m = (m + (64'sd1 <<< (sh - 1))) >>> sh;
         return (v < 0) ? -m : m;
      endfunction

      function logic [FIELD_W-1:0] clip(longint v);
         if (v > 8388607) v = 8388607;
         if (v < -8388608) v = -8388608;
         return v[FIELD_W-1:0];
      endfunction

      function longint wave(longint unsigned q);
         longint lenv;
         lenv = longint'((amplitude * envelope(q) + 128) >> 8);
         return round_off(lenv * cosine(q), 16);
      endfunction

      function void note_cell(logic [IN_W-1:0] cell_x);
         longint unsigned p;
         longint we;
         longint wb;
         p = 2 * longint'(cell_x);
         we = wave(p);
         wb = wave(p + 1);
         pending.push_back({clip(round_off(wb * pol_cos, 16)),
                            clip(-round_off(wb * pol_sin, 16)),
                            clip(round_off(we * pol_sin, 16)),
                            clip(round_off(we * pol_cos, 16))});
      endfunction

      function void check_fields(logic [4*FIELD_W-1:0] got);
         logic [4*FIELD_W-1:0] want;
         string names [4];
         bit bad;
         names = '{"e_y", "e_z", "b_y", "b_z"};
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected field transfer %h", got);
            return;
         end
         want = pending.pop_front();
         bad = 0;
         for (int f = 0; f < 4; f++)
            if (want[f*FIELD_W +: FIELD_W] !== got[f*FIELD_W +: FIELD_W]) begin
               bad = 1;
               if (errors < 10)
                  $display("%s mismatch: expected %0d actual %0d", names[f],
                           $signed(want[f*FIELD_W +: FIELD_W]),
                           $signed(got[f*FIELD_W +: FIELD_W]));
            end
         if (bad) errors++;
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [IN_W-1:0]       req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [4*FIELD_W-1:0]  rsp_tdata;
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;

   field_scoreboard sb;
   int idle_cycles;
   bit req_burst;
   bit rsp_burst;

   // directed cells around the pulse at start 400
   logic [IN_W-1:0] lo_cells [15] = '{0, 1, 50, 100, 150, 175, 180, 181, 185, 190,
                                       199, 200, 201, 16'h7FFF, 16'hFFFF};

   plane_wave_pulse_field_generator_unit u_top (.*);

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   task automatic write_cfg(longint unsigned sp, rl, fl, fa, ph, amp, pc, ps);
      logic [CSR_DATA_W-1:0] vals [8];
      vals = '{CSR_DATA_W'(sp), CSR_DATA_W'(rl), CSR_DATA_W'(fl), CSR_DATA_W'(fa),
               CSR_DATA_W'(ph), CSR_DATA_W'(amp), CSR_DATA_W'(pc), CSR_DATA_W'(ps)};
      for (int i = 0; i < 8; i++) begin
         csr_we <= 1;
         csr_addr <= csr_idx_type'(i);
         csr_wdata <= vals[i];
         sb.set_reg(csr_idx_type'(i), vals[i]);
         @(posedge clock);
      end
      csr_we <= 0;
   endtask

   task automatic send_cell(logic [IN_W-1:0] cell_x);
      int gap;
      if ($urandom_range(0, 39) == 0) req_burst = ~req_burst;
      gap = req_burst ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= cell_x;
      do @(posedge clock); while (!req_tready);
      sb.note_cell(cell_x);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (25) @(posedge clock);
   endtask

   // field readout side with its own stalls
   initial begin
      int gap;
      rsp_tready = 0;
      @(negedge reset);
      forever begin
         if ($urandom_range(0, 39) == 0) rsp_burst = ~rsp_burst;
         gap = rsp_burst ? 0 : $urandom_range(0, 9);
         if (gap > 0) begin
            rsp_tready <= 0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready) sb.check_fields(rsp_tdata);

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else if (idle_cycles >= 5000) begin
         $display("FAILED: results differ");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      longint unsigned sp, rl, fl, fa, span;
      longint unsigned lo;
      sb = new();
      reset = 1;
      req_tvalid = 0;
      req_tdata = 0;
      csr_we = 0;
      csr_addr = CSR_START;
      csr_wdata = 0;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // reset values: amplitude zero, all fields zero
      send_cell(0);
      send_cell(16'hFFFF);
      drain();

      // pulse across rise, flat and fall, full-scale products
      write_cfg(400, 40, 30, 50, 16'h1234, 16'hFFFF, 16'h8000, 16'h7FFF);
      foreach (lo_cells[i]) send_cell(lo_cells[i]);
      drain();

      // empty rise and fall regions
      write_cfg(300, 0, 20, 0, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h8000);
      for (int c = 138; c <= 152; c += 2) send_cell(IN_W'(c));
      drain();

      // register extremes, phase wraps
      write_cfg(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 16'hFFFF, 16'hFFFF,
                16'h8000, 16'h8000);
      send_cell(0);
      send_cell(16'hFFFF);
      send_cell(16'h5555);
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         sp = $urandom_range(0, 140000);
         if ($urandom_range(0, 3) == 0) begin
            rl = $urandom_range(0, 20'hFFFFF);
            fl = $urandom_range(0, 20'hFFFFF);
            fa = $urandom_range(0, 20'hFFFFF);
         end else begin
            rl = $urandom_range(1, 3000);
            fl = $urandom_range(0, 2000);
            fa = $urandom_range(1, 3000);
         end
         write_cfg(sp, rl, fl, fa, $urandom_range(0, 65535), $urandom_range(0, 65535),
                   $urandom_range(0, 65535), $urandom_range(0, 65535));
         span = rl + fl + fa + 20;
         for (int n = 0; n < 210; n++) begin
            if ($urandom_range(0, 4) == 0) send_cell(IN_W'($urandom_range(0, 65535)));
            else begin
               lo = $urandom_range(0, span);
               lo = (lo > sp) ? 0 : (sp - lo + 4) / 2;
               send_cell((lo > 65535) ? 16'hFFFF : lo[15:0]);
            end
         end
         drain();
      end

      if (sb.errors == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/pwpfg_pkg.sv
rtl/core/pwpfg_rom.sv
rtl/core/pwpfg_div.sv
rtl/core/pwpfg_lane.sv
rtl/core/plane_wave_pulse_field_generator_unit.sv
bench/tb.sv
